// File: hdl/tkrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkrs_pkg
// Shared widths, command codes, queue and result types and the ratio compare
// for the top-K ratio score keeper.
// ----------------------------------------------------------------------------
package tkrs_pkg;

  localparam int KEEP_SLOTS  = 8;
  localparam int SLOT_W      = (KEEP_SLOTS > 1) ? $clog2(KEEP_SLOTS) : 1;
  localparam int TOTAL_W     = $clog2(KEEP_SLOTS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W = 2;
  localparam int ID_W  = 16;
  localparam int CNT_W = 8;
  localparam int LEN_W = 8;
  localparam int THR_W = 9;
  localparam int Q_FRAC = 8;
  localparam int PROD_W = CNT_W + LEN_W;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_OFFER = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t             op;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] len;
  } q_entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] len;
    logic             entry_valid;
    logic             last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_REPLACE,
    ST_SELECT,
    ST_EMIT,
    ST_EMPTY
  } back_state_t;

  // ca/la < cb/lb, lengths nonzero
  function automatic logic ratio_less(input logic [CNT_W-1:0] ca,
                                      input logic [LEN_W-1:0] la,
                                      input logic [CNT_W-1:0] cb,
                                      input logic [LEN_W-1:0] lb);
    logic [PROD_W-1:0] left;
    logic [PROD_W-1:0] right;
    left  = ca * lb;
    right = cb * la;
    return left < right;
  endfunction

endpackage
`default_nettype wire

// File: hdl/tkrs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkrs_if
// Valid/ready channels: command items, result items and the threshold write.
// ----------------------------------------------------------------------------
interface tkrs_item_if;
  logic                          valid;
  logic                          ready;
  logic [tkrs_pkg::CMD_W-1:0]    cmd;
  logic [tkrs_pkg::ID_W-1:0]     item_id;
  logic [tkrs_pkg::CNT_W-1:0]    match_count;
  logic [tkrs_pkg::LEN_W-1:0]    cand_length;
  modport source (output valid, cmd, item_id, match_count, cand_length, input ready);
  modport sink   (input valid, cmd, item_id, match_count, cand_length, output ready);
endinterface

interface tkrs_result_if;
  logic                          valid;
  logic                          ready;
  logic [tkrs_pkg::ID_W-1:0]     entry_id;
  logic [tkrs_pkg::CNT_W-1:0]    entry_count;
  logic [tkrs_pkg::LEN_W-1:0]    entry_length;
  logic                          entry_valid;
  logic                          last;
  modport source (output valid, entry_id, entry_count, entry_length, entry_valid, last,
                  input ready);
  modport sink   (input valid, entry_id, entry_count, entry_length, entry_valid, last,
                  output ready);
endinterface

interface tkrs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tkrs_pkg::THR_W-1:0]    score_threshold_q8;
  modport source (output valid, score_threshold_q8, input ready);
  modport sink   (input valid, score_threshold_q8, output ready);
endinterface
`default_nettype wire

// File: hdl/tkrs_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkrs_front
// Accept command items, hold the threshold register, drop unused codes and
// offers that cannot enter the store, and push the rest into the queue.
// ----------------------------------------------------------------------------
module tkrs_front (
  input  wire logic              clk,
  input  wire logic              rst,
  tkrs_item_if.sink              item,
  tkrs_cfg_if.sink               cfg,
  input  wire tkrs_pkg::q_status_t q_status,
  output logic                   q_push,
  output tkrs_pkg::q_entry_t     q_entry
);
  import tkrs_pkg::*;

  logic [THR_W-1:0]        threshold;
  logic [THR_W+LEN_W-1:0]  thr_prod;
  logic [THR_W+LEN_W-1:0]  cnt_scaled;
  logic                    offer_ok;
  logic                    keep;

  assign cfg.ready  = 1'b1;
  assign item.ready = !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      threshold <= cfg.score_threshold_q8;
    end
  end

  // count * 256 >= threshold * length
  assign thr_prod   = threshold * item.cand_length;
  assign cnt_scaled = (THR_W+LEN_W)'({item.match_count, {Q_FRAC{1'b0}}});
  assign offer_ok   = (item.match_count != '0) && (item.cand_length != '0) &&
                      (cnt_scaled >= thr_prod);

  always_comb begin
    case (item.cmd)
      CMD_CLEAR: keep = 1'b1;
      CMD_OFFER: keep = offer_ok;
      CMD_READ:  keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign q_push      = item.valid && item.ready && keep;
  assign q_entry.op  = cmd_t'(item.cmd);
  assign q_entry.id  = item.item_id;
  assign q_entry.cnt = item.match_count;
  assign q_entry.len = item.cand_length;

endmodule
`default_nettype wire

// File: hdl/tkrs_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkrs_queue
// Short command queue between front and back; head is shown until popped.
// ----------------------------------------------------------------------------
module tkrs_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tkrs_pkg::q_entry_t push_entry,
  input  wire logic              pop,
  output tkrs_pkg::q_entry_t     head,
  output tkrs_pkg::q_status_t    status
);
  import tkrs_pkg::*;

  q_entry_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head             = entries[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/tkrs_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tkrs_back
// Slot store and its scanner: fill, worst-slot replacement and sorted readout
// through one slot compare per cycle, with a registered result stage.
// ----------------------------------------------------------------------------
module tkrs_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tkrs_pkg::q_entry_t  q_head,
  input  wire tkrs_pkg::q_status_t q_status,
  output logic                   q_pop,
  tkrs_result_if.source          result
);
  import tkrs_pkg::*;

  back_state_t        state;
  back_state_t        state_next;

  logic [ID_W-1:0]    slot_id     [KEEP_SLOTS];
  logic [CNT_W-1:0]   slot_count  [KEEP_SLOTS];
  logic [LEN_W-1:0]   slot_length [KEEP_SLOTS];
  logic [TOTAL_W-1:0] kept_total;

  logic [SLOT_W-1:0]  scan;
  logic [SLOT_W-1:0]  pick_idx;
  logic [ID_W-1:0]    pick_id;
  logic [CNT_W-1:0]   pick_cnt;
  logic [LEN_W-1:0]   pick_len;
  logic               pick_have;
  logic [KEEP_SLOTS-1:0] emitted;
  logic [TOTAL_W-1:0] rank;

  res_t               res;
  logic               res_valid;
  logic               res_load;

  logic [ID_W-1:0]    scan_id;
  logic [CNT_W-1:0]   scan_cnt;
  logic [LEN_W-1:0]   scan_len;
  logic               scan_last;
  logic               scan_eligible;
  logic               scan_worse;
  logic               scan_better;
  logic               store_full;
  logic               out_free;
  logic               beats_worst;
  logic               is_last;

  assign scan_id       = slot_id[scan];
  assign scan_cnt      = slot_count[scan];
  assign scan_len      = slot_length[scan];
  assign scan_last     = (scan == SLOT_W'(KEEP_SLOTS - 1));
  assign scan_eligible = (TOTAL_W'(scan) < kept_total) && !emitted[scan];
  assign scan_worse    = ratio_less(scan_cnt, scan_len, pick_cnt, pick_len);
  assign scan_better   = ratio_less(pick_cnt, pick_len, scan_cnt, scan_len);
  assign store_full    = (kept_total == TOTAL_W'(KEEP_SLOTS));
  assign out_free      = !res_valid || result.ready;
  assign beats_worst   = ratio_less(pick_cnt, pick_len, q_head.cnt, q_head.len);
  assign is_last       = (rank == kept_total - TOTAL_W'(1));
  assign res_load      = out_free && (state inside {ST_EMIT, ST_EMPTY});

  assign result.valid        = res_valid;
  assign result.entry_id     = res.id;
  assign result.entry_count  = res.cnt;
  assign result.entry_length = res.len;
  assign result.entry_valid  = res.entry_valid;
  assign result.last         = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_status.not_empty) begin
          case (q_head.op)
            CMD_CLEAR: q_pop = 1'b1;
            CMD_OFFER: begin
              if (store_full) begin
                state_next = ST_FIND;
              end else begin
                q_pop = 1'b1;
              end
            end
            CMD_READ: begin
              state_next = (kept_total == '0) ? ST_EMPTY : ST_SELECT;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_FIND: begin
        if (scan_last) begin
          state_next = ST_REPLACE;
        end
      end
      ST_REPLACE: begin
        q_pop      = 1'b1;
        state_next = ST_IDLE;
      end
      ST_SELECT: begin
        if (scan_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (is_last) begin
            q_pop      = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_SELECT;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          q_pop      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // slot store
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_status.not_empty && q_head.op == CMD_OFFER && !store_full) begin
      slot_id[kept_total[SLOT_W-1:0]]     <= q_head.id;
      slot_count[kept_total[SLOT_W-1:0]]  <= q_head.cnt;
      slot_length[kept_total[SLOT_W-1:0]] <= q_head.len;
    end else if (state == ST_REPLACE && beats_worst) begin
      slot_id[pick_idx]     <= q_head.id;
      slot_count[pick_idx]  <= q_head.cnt;
      slot_length[pick_idx] <= q_head.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_total <= '0;
      res_valid  <= 1'b0;
    end else begin
      // a new result takes the register even as the old one leaves
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          scan      <= '0;
          pick_have <= 1'b0;
          emitted   <= '0;
          rank      <= '0;
          if (q_status.not_empty) begin
            if (q_head.op == CMD_CLEAR) begin
              kept_total <= '0;
            end else if (q_head.op == CMD_OFFER && !store_full) begin
              kept_total <= kept_total + 1'b1;
            end
          end
        end
        ST_FIND: begin
          // earliest lowest score: replace only on strictly lower
          if (!pick_have || scan_worse) begin
            pick_idx  <= scan;
            pick_cnt  <= scan_cnt;
            pick_len  <= scan_len;
            pick_have <= 1'b1;
          end
          scan <= scan + 1'b1;
        end
        ST_SELECT: begin
          // highest score not yet sent, ties to the lower slot
          if (scan_eligible && (!pick_have || scan_better)) begin
            pick_idx  <= scan;
            pick_id   <= scan_id;
            pick_cnt  <= scan_cnt;
            pick_len  <= scan_len;
            pick_have <= 1'b1;
          end
          scan <= scan + 1'b1;
        end
        ST_EMIT: begin
          if (out_free) begin
            res.id            <= pick_id;
            res.cnt           <= pick_cnt;
            res.len           <= pick_len;
            res.entry_valid   <= 1'b1;
            res.last          <= is_last;
            emitted[pick_idx] <= 1'b1;
            rank              <= rank + 1'b1;
            scan              <= '0;
            pick_have         <= 1'b0;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            res.id          <= '0;
            res.cnt         <= '0;
            res.len         <= '0;
            res.entry_valid <= 1'b0;
            res.last        <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    kept_total <= TOTAL_W'(KEEP_SLOTS))
    else $error("kept_total exceeds slot count");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.entry_valid) |-> res.last)
    else $error("empty readout result not marked last");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_status.not_empty)
    else $error("queue popped while empty");

  a_rank_tracks_sent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SELECT) |-> ($countones(emitted) == int'(rank)))
    else $error("sent mask out of step with rank");
`endif

endmodule
`default_nettype wire

// File: hdl/top_k_ratio_score_keeper.sv
// Back end: clear and an offer into a free slot are handled straight from idle;
// an offer into a full store scans every slot (one slot compare a cycle), then replaces.
// Readout of n entries: each result takes its own selection scan over all slots,
// paced by the single slot scanner; an empty readout gives one empty result.
// Reset (synchronous): store empty, threshold 128, queue empty; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_ratio_score_keeper
// Keeps the best KEEP_SLOTS candidates by count/length ratio and reads them
// out in descending score order.
// ----------------------------------------------------------------------------
module top_k_ratio_score_keeper (
  input  wire logic      clk,
  input  wire logic      rst,
  tkrs_item_if.sink      item,
  tkrs_cfg_if.sink       cfg,
  tkrs_result_if.source  result
);
  import tkrs_pkg::*;

  // Front: take each command transaction, check offers against the
  // threshold and drop those that cannot change the store, along with the
  // unused command code. Only useful work goes into the queue.
  q_status_t q_status;
  logic      q_push;
  q_entry_t  q_entry;

  // Back side of the queue: the head stays put until the back end finishes
  // the command, so a long readout holds the queue while the front keeps
  // taking transactions until the queue fills.
  logic      q_pop;
  q_entry_t  q_head;

  tkrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .q_status (q_status),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  tkrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // Back: slot store plus a one-compare-per-cycle scanner. A full-store
  // offer scans for the earliest lowest slot, then replaces it on a strictly
  // better score. A readout repeats a selection scan per result and parks
  // each result in the output register, which decouples the result sink.
  tkrs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_status (q_status),
    .q_pop    (q_pop),
    .result   (result)
  );

endmodule
`default_nettype wire
